// File: hdl/kvlt_pkg.sv
// Shared types and constants for the keyframe vec3 lerp track.
// Holds the channel word structs, command and status codes, and datapath widths.
// No dependencies.
package kvlt_pkg;

  localparam int FRAME_W = 16;
  localparam int FRAC_W  = 8;
  localparam int POS_W   = FRAME_W + FRAC_W;
  localparam int VAL_W   = 32;
  localparam int W_BITS  = 16;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  typedef struct packed {
    logic                    cmd;
    logic [POS_W-1:0]        frame_pos;
    logic signed [VAL_W-1:0] value_x;
    logic signed [VAL_W-1:0] value_y;
    logic signed [VAL_W-1:0] value_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic w_bit;
  } lerp_ctl_t;

endpackage

// File: hdl/kvlt_div.sv
// Bit-serial restoring divider producing the Q0.16 interpolation weight.
// One quotient bit per step; the caller sequences the steps.
// Depends on kvlt_pkg.
module kvlt_div (
  input  logic                        clk,
  input  kvlt_pkg::div_ctl_t          ctl,
  input  logic [kvlt_pkg::POS_W-1:0]  num,
  input  logic [kvlt_pkg::POS_W-1:0]  den,
  output logic [kvlt_pkg::W_BITS-1:0] quo
);

  logic [kvlt_pkg::POS_W-1:0]  rem_r;
  logic [kvlt_pkg::POS_W-1:0]  den_r;
  logic [kvlt_pkg::W_BITS-1:0] quo_r;
  logic [kvlt_pkg::POS_W:0]    trial;
  logic [kvlt_pkg::POS_W:0]    diff;
  logic                        ge;

  assign trial = {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= num;
      den_r <= den;
      quo_r <= '0;
    end else if (ctl.step) begin
      rem_r <= ge ? diff[kvlt_pkg::POS_W-1:0] : trial[kvlt_pkg::POS_W-1:0];
      quo_r <= {quo_r[kvlt_pkg::W_BITS-2:0], ge};
    end
  end

  assign quo = quo_r;

endmodule

// File: hdl/kvlt_lerp.sv
// One axis of the lerp: a + floor((b - a) * w / 65536) by serial shift-add.
// Takes one weight bit per step, least significant first.
// Depends on kvlt_pkg.
module kvlt_lerp (
  input  logic                              clk,
  input  kvlt_pkg::lerp_ctl_t               ctl,
  input  logic signed [kvlt_pkg::VAL_W-1:0] a_in,
  input  logic signed [kvlt_pkg::VAL_W-1:0] b_in,
  output logic signed [kvlt_pkg::VAL_W-1:0] result
);

  localparam int D_W   = kvlt_pkg::VAL_W + 1;
  localparam int ACC_W = kvlt_pkg::VAL_W + 3;

  logic signed [kvlt_pkg::VAL_W-1:0] a_r;
  logic signed [D_W-1:0]             d_r;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           sum;

  assign sum = acc_r + (ctl.w_bit ? ACC_W'(d_r) : ACC_W'(0));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r   <= a_in;
      d_r   <= D_W'(b_in) - D_W'(a_in);
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= sum >>> 1;
    end
  end

  assign result = a_r + acc_r[kvlt_pkg::VAL_W-1:0];

endmodule

// File: hdl/keyframe_vec3_lerp_track.sv
// Keyframe track of 3-component Q16.16 values with linear interpolation.
// Holds the key tables, the command sequencer and the serial divide and lerp units.
// Depends on kvlt_pkg, kvlt_div and kvlt_lerp.
//
// Usage: in_word carries a command. An add appends a key (integer part of
// frame_pos, x, y, z) when the table has room and the frame is above the last
// key; otherwise status reports table full or frame not increasing. A query
// returns the value at the fractional frame: exact key, interpolation between
// the bracketing keys, first key before the track, last key past it, zeros
// when the track is empty. Every word in gives exactly one word out.
// Sequence: an add or an empty-track query goes straight to the finish state.
// A query walks the key frame memory one key per cycle; it copies the key
// values when it resolves on a key without interpolation, and when it
// interpolates it runs value loads, serial divide and serial multiply.
// One word is in flight at a time; in_stall is high until the result moves to
// the output register, which holds while out_stall is high.
// Reset empties the track and holds in_stall high; the key memories need no clearing.
module keyframe_vec3_lerp_track #(
  parameter int MAX_KEYS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kvlt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output kvlt_pkg::out_word_t out_word
);

  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int STEP_W = $clog2(kvlt_pkg::W_BITS + 1);
  localparam int VEC_W  = 3 * kvlt_pkg::VAL_W;
  localparam int FW     = kvlt_pkg::FRAME_W;
  localparam int PW     = kvlt_pkg::POS_W;
  localparam int VW     = kvlt_pkg::VAL_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_CPY  = 3'd2;
  localparam logic [2:0] S_LDA  = 3'd3;
  localparam logic [2:0] S_LDB  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_MUL  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [FW-1:0]     frames_mem [MAX_KEYS];
  logic [VEC_W-1:0]  vals_mem   [MAX_KEYS];

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [FW-1:0]     last_frame_r;
  logic [PW-1:0]     pos_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FW-1:0]     prev_frame_r;
  logic [STEP_W-1:0] step_r;
  logic [kvlt_pkg::W_BITS-1:0] w_r;
  logic [VEC_W-1:0]  a_r;
  kvlt_pkg::out_word_t res_r;
  kvlt_pkg::out_word_t out_word_r;
  logic              out_valid_r;

  logic [FW-1:0]     frame_q;
  logic [VEC_W-1:0]  val_q;
  logic [IDX_W-1:0]  val_raddr;

  logic              in_acc;
  logic              tbl_full;
  logic              order_bad;
  logic              add_ok;
  logic [FW-1:0]     add_frame;
  logic [PW-1:0]     kf;
  logic [PW-1:0]     pf;
  logic              hit;
  logic              after;
  logic              at_last;
  logic              out_load;

  kvlt_pkg::div_ctl_t  div_ctl;
  kvlt_pkg::lerp_ctl_t lerp_ctl;
  logic [kvlt_pkg::W_BITS-1:0] quo;
  logic signed [VW-1:0] rx, ry, rz;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign in_acc    = in_valid && !in_stall;
  assign add_frame = in_word.frame_pos[PW-1:kvlt_pkg::FRAC_W];
  assign tbl_full  = count_r == CNT_W'(MAX_KEYS);
  assign order_bad = (count_r != '0) && (add_frame <= last_frame_r);
  assign add_ok    = in_acc && (in_word.cmd == kvlt_pkg::CMD_ADD) && !tbl_full && !order_bad;

  assign kf      = {frame_q, {kvlt_pkg::FRAC_W{1'b0}}};
  assign pf      = {prev_frame_r, {kvlt_pkg::FRAC_W{1'b0}}};
  assign after   = kf > pos_r;
  assign hit     = (kf == pos_r) || (after && (idx_r == '0));
  assign at_last = CNT_W'(idx_r) == (count_r - 1'b1);

  assign out_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (add_ok) begin
      frames_mem[count_r[IDX_W-1:0]] <= add_frame;
    end
    frame_q <= frames_mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (add_ok) begin
      vals_mem[count_r[IDX_W-1:0]] <= {in_word.value_x, in_word.value_y, in_word.value_z};
    end
    val_q <= vals_mem[val_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    val_raddr     = idx_r;
    div_ctl.start = 1'b0;
    div_ctl.step  = 1'b0;
    lerp_ctl.load = 1'b0;
    lerp_ctl.step = 1'b0;
    lerp_ctl.w_bit = w_r[0];
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          if (in_word.cmd == kvlt_pkg::CMD_QUERY && count_r != '0) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SRCH: begin
        priority if (hit || (!after && at_last)) begin
          state_nxt = S_CPY;
        end else if (after) begin
          val_raddr     = idx_r - 1'b1;
          div_ctl.start = 1'b1;
          state_nxt     = S_LDA;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_CPY: state_nxt = S_FIN;
      S_LDA: state_nxt = S_LDB;
      S_LDB: begin
        lerp_ctl.load = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (step_r == STEP_W'(kvlt_pkg::W_BITS)) begin
          state_nxt = S_MUL;
        end else begin
          div_ctl.step = 1'b1;
        end
      end
      S_MUL: begin
        if (step_r == STEP_W'(kvlt_pkg::W_BITS)) begin
          state_nxt = S_FIN;
        end else begin
          lerp_ctl.step = 1'b1;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (add_ok) begin
        count_r <= count_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (add_ok) begin
      last_frame_r <= add_frame;
    end
    if (out_load) begin
      out_word_r <= res_r;
    end
    unique case (state_r)
      S_IDLE: begin
        pos_r <= in_word.frame_pos;
        res_r <= '0;
        if (in_acc && in_word.cmd == kvlt_pkg::CMD_ADD) begin
          priority if (tbl_full) begin
            res_r.status <= kvlt_pkg::ST_FULL;
          end else if (order_bad) begin
            res_r.status <= kvlt_pkg::ST_ORDER;
          end else begin
            res_r.status <= kvlt_pkg::ST_OK;
          end
        end
      end
      S_SRCH: begin
        prev_frame_r <= frame_q;
      end
      S_CPY: begin
        res_r.out_x <= val_q[3*VW-1:2*VW];
        res_r.out_y <= val_q[2*VW-1:VW];
        res_r.out_z <= val_q[VW-1:0];
      end
      S_LDA: begin
        a_r    <= val_q;
        step_r <= '0;
      end
      S_LDB: begin
        step_r <= '0;
      end
      S_DIV: begin
        if (step_r == STEP_W'(kvlt_pkg::W_BITS)) begin
          step_r <= '0;
          w_r    <= quo;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      S_MUL: begin
        if (step_r == STEP_W'(kvlt_pkg::W_BITS)) begin
          res_r.out_x <= rx;
          res_r.out_y <= ry;
          res_r.out_z <= rz;
        end else begin
          step_r <= step_r + 1'b1;
          w_r    <= w_r >> 1;
        end
      end
      S_FIN: begin
      end
    endcase
  end

  kvlt_div u_div (
    .clk (clk),
    .ctl (div_ctl),
    .num (pos_r - pf),
    .den (kf - pf),
    .quo (quo)
  );

  kvlt_lerp u_lerp_x (
    .clk    (clk),
    .ctl    (lerp_ctl),
    .a_in   (a_r[3*VW-1:2*VW]),
    .b_in   (val_q[3*VW-1:2*VW]),
    .result (rx)
  );

  kvlt_lerp u_lerp_y (
    .clk    (clk),
    .ctl    (lerp_ctl),
    .a_in   (a_r[2*VW-1:VW]),
    .b_in   (val_q[2*VW-1:VW]),
    .result (ry)
  );

  kvlt_lerp u_lerp_z (
    .clk    (clk),
    .ctl    (lerp_ctl),
    .a_in   (a_r[VW-1:0]),
    .b_in   (val_q[VW-1:0]),
    .result (rz)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KEYS))
    else $error("key count beyond table size");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_word.cmd == kvlt_pkg::CMD_ADD && tbl_full |=> $stable(count_r))
    else $error("rejected add changed key count");

  a_srch_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> CNT_W'(idx_r) < count_r)
    else $error("search index past last key");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL && step_r == STEP_W'(kvlt_pkg::W_BITS) |=> state_r == S_FIN)
    else $error("multiply did not finish");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.status != kvlt_pkg::ST_OK |->
      out_word_r.out_x == '0 && out_word_r.out_y == '0 && out_word_r.out_z == '0)
    else $error("rejected add carries nonzero value");
`endif

endmodule
